// ===== rtl/three_level_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_defines
// assertion macros used by the priority queue top level
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TLPQ_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tlpq same-cycle check failed");

// next-cycle implication, disabled in reset
`define TLPQ_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tlpq next-cycle check failed");

`endif

// ===== rtl/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg
// sizes, codes and control types of the three level priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

    // entry store geometry
    localparam int DEPTH         = 64;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int PAYLOAD_WIDTH = 32;

    // fixed field widths of the channels
    localparam int REQ_W   = 2;
    localparam int PRIO_W  = 2;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int HELD_W  = 7;

    // levels
    localparam int NUM_LEVELS = 3;
    localparam int LVL_W      = 2;
    localparam logic [LVL_W-1:0] LVL_LOW     = 2'd0;
    localparam logic [LVL_W-1:0] LVL_NORMAL  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_INVALID = 2'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_ACCEL = 2'd2
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_PUT   = 2'd1,
        OP_GET   = 2'd2,
        OP_ACCEL = 2'd3
    } op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // successor of an entry in the free chain after reset
    function automatic logic [IDX_W-1:0] chain_next(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1))
            return '0;
        else
            return IDX_W'(i + IDX_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tlpq_req_if.sv =====
// ----------------------------------------------------------------------------
// tlpq_req_if
// request channel: put, get or accelerate
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  priority_req;
    logic [31:0] payload;

    modport source (output valid, req_type, priority_req, payload, input ready);
    modport sink   (input valid, req_type, priority_req, payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/tlpq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tlpq_rsp_if
// response channel: popped data, status and fill level
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_payload;
    logic [1:0]  status;
    logic [6:0]  entries_held;

    modport source (output valid, out_payload, status, entries_held, input ready);
    modport sink   (input valid, out_payload, status, entries_held, output ready);
endinterface

`default_nettype wire

// ===== rtl/tlpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpq_ctrl
// two-state sequencer: take an item, then commit it once the result slot frees
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire tlpq_pkg::dp_status_t sts,
    output logic                      in_ready,
    output tlpq_pkg::ctl_cmd_t        cmd
);
    import tlpq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_EXEC:
            begin
                cmd.commit = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tlpq_datapath.sv =====
// ----------------------------------------------------------------------------
// tlpq_datapath
// level lists, free list, link and payload memories, result register
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tlpq_pkg::ctl_cmd_t   cmd,
    output tlpq_pkg::dp_status_t      sts,
    input  wire logic [1:0]           req_type,
    input  wire logic [1:0]           priority_req,
    input  wire logic [31:0]          payload,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               out_payload,
    output logic [1:0]                status,
    output logic [6:0]                entries_held
);
    import tlpq_pkg::*;

    // memories
    logic [PAYLOAD_WIDTH-1:0] pl_mem [DEPTH];
    logic [IDX_W-1:0]         nx_mem [DEPTH];

    // link entries written since reset; others read as the reset chain
    logic [DEPTH-1:0]         nx_written_reg;

    logic [PAYLOAD_WIDTH-1:0] pl_rd_reg;
    logic [IDX_W-1:0]         nx_rd_reg;
    logic                     nx_rd_vld_reg;

    // list state
    logic [IDX_W-1:0] head_reg  [NUM_LEVELS];
    logic [IDX_W-1:0] head_next [NUM_LEVELS];
    logic [IDX_W-1:0] tail_reg  [NUM_LEVELS];
    logic [IDX_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_reg   [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_next  [NUM_LEVELS];
    logic [IDX_W-1:0] free_head_reg;
    logic [IDX_W-1:0] free_head_next;
    logic [CNT_W-1:0] free_cnt_reg;
    logic [CNT_W-1:0] free_cnt_next;

    // latched request
    op_t              op_reg;
    logic [LVL_W-1:0] lvl_reg;
    status_t          stat_reg;
    logic [IDX_W-1:0] idx_reg;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DATA_W-1:0]        out_payload_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [HELD_W-1:0]        out_held_reg;

    // decode of the incoming item
    op_t              dec_op;
    logic [LVL_W-1:0] dec_lvl;
    status_t          dec_stat;
    logic [IDX_W-1:0] dec_idx;

    // memory port controls
    logic                     pl_we;
    logic                     pl_re;
    logic                     nx_we;
    logic                     nx_re;
    logic [IDX_W-1:0]         nx_waddr;
    logic [IDX_W-1:0]         nx_wdata;
    logic [IDX_W-1:0]         nx_eff;

    assign sts.out_free = !out_valid_reg || out_ready;

    // classify the request against the current list state
    always_comb
    begin
        dec_op   = OP_NONE;
        dec_lvl  = LVL_LOW;
        dec_stat = ST_OK;
        dec_idx  = free_head_reg;
        unique case (req_type)
            REQ_PUT:
            begin
                if (priority_req == LVL_INVALID)
                    dec_stat = ST_INVALID;
                else if (free_cnt_reg == '0)
                    dec_stat = ST_FULL;
                else
                begin
                    dec_op  = OP_PUT;
                    dec_lvl = priority_req;
                end
            end
            REQ_GET:
            begin
                dec_op = OP_GET;
                priority if (cnt_reg[LVL_HIGH] != '0)
                    dec_lvl = LVL_HIGH;
                else if (cnt_reg[LVL_NORMAL] != '0)
                    dec_lvl = LVL_NORMAL;
                else if (cnt_reg[LVL_LOW] != '0)
                    dec_lvl = LVL_LOW;
                else
                begin
                    dec_op   = OP_NONE;
                    dec_stat = ST_EMPTY;
                end
                dec_idx = head_reg[dec_lvl];
            end
            REQ_ACCEL:
            begin
                if (cnt_reg[LVL_LOW] != '0)
                    dec_op = OP_ACCEL;
            end
            default: ;
        endcase
    end

    // memory ports: payload write, link-in and reads on accept, link rewrite on commit
    always_comb
    begin
        pl_we    = 1'b0;
        pl_re    = 1'b0;
        nx_we    = 1'b0;
        nx_re    = 1'b0;
        nx_waddr = tail_reg[LVL_HIGH];
        nx_wdata = '0;
        if (cmd.accept)
        begin
            unique case (dec_op)
                OP_PUT:
                begin
                    pl_we    = 1'b1;
                    nx_re    = 1'b1;
                    nx_we    = (cnt_reg[dec_lvl] != '0);
                    nx_waddr = tail_reg[dec_lvl];
                    nx_wdata = free_head_reg;
                end
                OP_GET:
                begin
                    pl_re = 1'b1;
                    nx_re = 1'b1;
                end
                OP_ACCEL:
                begin
                    nx_we    = (cnt_reg[LVL_HIGH] != '0);
                    nx_waddr = tail_reg[LVL_HIGH];
                    nx_wdata = head_reg[LVL_LOW];
                end
                default: ;
            endcase
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_PUT:
                begin
                    nx_we    = 1'b1;
                    nx_waddr = idx_reg;
                    nx_wdata = '0;
                end
                OP_GET:
                begin
                    nx_we    = 1'b1;
                    nx_waddr = idx_reg;
                    nx_wdata = free_head_reg;
                end
                default: ;
            endcase
        end
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (pl_we)
            pl_mem[dec_idx] <= PAYLOAD_WIDTH'(payload);
        if (pl_re)
            pl_rd_reg <= pl_mem[dec_idx];
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (nx_we)
            nx_mem[nx_waddr] <= nx_wdata;
        if (nx_re)
            nx_rd_reg <= nx_mem[dec_idx];
    end

    // written marks of the link memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_written_reg <= '0;
            nx_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (nx_we)
                nx_written_reg[nx_waddr] <= 1'b1;
            if (nx_re)
                nx_rd_vld_reg <= nx_written_reg[dec_idx];
        end
    end

    // successor of the latched entry
    assign nx_eff = nx_rd_vld_reg ? nx_rd_reg : chain_next(idx_reg);

    // latch the decoded request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_NONE;
            lvl_reg  <= LVL_LOW;
            stat_reg <= ST_OK;
            idx_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            op_reg   <= dec_op;
            lvl_reg  <= dec_lvl;
            stat_reg <= dec_stat;
            idx_reg  <= dec_idx;
        end
    end

    // list updates on commit
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        if (cmd.commit)
        begin
            unique case (op_reg)
                OP_PUT:
                begin
                    free_head_next = nx_eff;
                    free_cnt_next  = CNT_W'(free_cnt_reg - CNT_W'(1));
                    if (cnt_reg[lvl_reg] == '0)
                        head_next[lvl_reg] = idx_reg;
                    tail_next[lvl_reg] = idx_reg;
                    cnt_next[lvl_reg]  = CNT_W'(cnt_reg[lvl_reg] + CNT_W'(1));
                end
                OP_GET:
                begin
                    free_head_next = idx_reg;
                    free_cnt_next  = CNT_W'(free_cnt_reg + CNT_W'(1));
                    cnt_next[lvl_reg] = CNT_W'(cnt_reg[lvl_reg] - CNT_W'(1));
                    if (cnt_reg[lvl_reg] == CNT_W'(1))
                    begin
                        head_next[lvl_reg] = '0;
                        tail_next[lvl_reg] = '0;
                    end
                    else
                        head_next[lvl_reg] = nx_eff;
                end
                OP_ACCEL:
                begin
                    if (cnt_reg[LVL_HIGH] == '0)
                        head_next[LVL_HIGH] = head_reg[LVL_LOW];
                    tail_next[LVL_HIGH] = tail_reg[LVL_LOW];
                    cnt_next[LVL_HIGH]  = CNT_W'(cnt_reg[LVL_HIGH] + cnt_reg[LVL_LOW]);
                    head_next[LVL_LOW]  = '0;
                    tail_next[LVL_LOW]  = '0;
                    cnt_next[LVL_LOW]   = '0;
                end
                default: ;
            endcase
        end
    end

    // list state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            free_head_reg <= '0;
            free_cnt_reg  <= CNT_W'(DEPTH);
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
        end
    end

    // result valid
    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_payload_reg <= (op_reg == OP_GET) ? DATA_W'(pl_rd_reg) : '0;
            out_status_reg  <= stat_reg;
            out_held_reg    <= HELD_W'(CNT_W'(DEPTH) - free_cnt_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_payload  = out_payload_reg;
    assign status       = out_status_reg;
    assign entries_held = out_held_reg;

endmodule

`default_nettype wire

// ===== rtl/three_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue
// strict priority queue, three fifo levels as linked lists in a shared store
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+------------------------------------------
//  req     | in  | req_type, priority_req, payload
//  rsp     | out | out_payload, status, entries_held
//
//  every request is taken in the idle state, where the link memory is read,
//  and committed from the exec state, where the link memory is rewritten.
//  after reset the free chain is implied by per-entry written marks that
//  reset clears at once, so no clearing pass is needed.
//  a new item is taken while a result waits; its commit stalls until rsp
//  takes the waiting result.
`default_nettype none

`include "three_level_priority_queue_defines.svh"

module three_level_priority_queue (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlpq_req_if.sink    req,
    tlpq_rsp_if.source  rsp
);
    import tlpq_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    // sequencer
    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // lists, memories and result register
    tlpq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req.req_type),
        .priority_req (req.priority_req),
        .payload      (req.payload),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_payload  (rsp.out_payload),
        .status       (rsp.status),
        .entries_held (rsp.entries_held)
    );

    // checks
    `TLPQ_ASSERT_NXT(a_one_item_at_work, clk, rst_n, req.valid && req.ready, !req.ready)
    `TLPQ_ASSERT_IMP(a_result_from_commit, clk, rst_n, $rose(rsp.valid), $past(cmd.commit))
    `TLPQ_ASSERT_IMP(a_held_bound, clk, rst_n, rsp.valid, rsp.entries_held <= HELD_W'(DEPTH))
    `TLPQ_ASSERT_IMP(a_fail_no_data, clk, rst_n, rsp.valid && (rsp.status != ST_OK), rsp.out_payload == '0)

endmodule

`default_nettype wire

// ===== tb/tlpq_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_tb_pkg
// scoreboard for the three level priority queue: keeps one fifo per level,
// works out the response of every accepted request and checks the responses
// of the block against them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package tlpq_tb_pkg;

    import tlpq_pkg::*;

    // request code with no meaning, the block must leave its state alone
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // mismatch lines printed before going quiet, all are still counted
    localparam int MAX_REPORT_LINES = 40;

    typedef struct packed {
        logic [DATA_W-1:0] out_payload;
        status_t           status;
        logic [HELD_W-1:0] entries_held;
    } rsp_item_t;

    class tlpq_scoreboard;

        // level contents, index equals level code so high is the top index
        logic [DATA_W-1:0] level_q [NUM_LEVELS][$];
        rsp_item_t         due_rsp [$];
        int                errors;
        int                rsp_seen;

        function void report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORT_LINES)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function int held_total();
            int sum;
            sum = 0;
            for (int l = 0; l < NUM_LEVELS; l++)
                sum += level_q[l].size();
            return sum;
        endfunction

        // add an entry behind the tail of one level
        function void level_append(int l, logic [DATA_W-1:0] d);
            level_q[l].insert(level_q[l].size(), d);
        endfunction

        // remove and return the oldest entry of one level
        function logic [DATA_W-1:0] level_take(int l);
            logic [DATA_W-1:0] d;
            d = level_q[l][0];
            level_q[l].delete(0);
            return d;
        endfunction

        // apply one request to the level fifos and return its response
        function rsp_item_t queue_response(logic [REQ_W-1:0] kind,
                                           logic [PRIO_W-1:0] lvl,
                                           logic [DATA_W-1:0] data);
            rsp_item_t r;
            r.out_payload = '0;
            r.status      = ST_OK;
            case (kind)
                REQ_PUT:
                begin
                    // invalid level wins over full
                    if (lvl == LVL_INVALID)
                        r.status = ST_INVALID;
                    else if (held_total() == DEPTH)
                        r.status = ST_FULL;
                    else
                        level_append(lvl, data);
                end
                REQ_GET:
                begin
                    // strict priority: scan from high down to low
                    r.status = ST_EMPTY;
                    for (int l = NUM_LEVELS - 1; l >= 0 && r.status == ST_EMPTY; l--)
                    begin
                        if (level_q[l].size() != 0)
                        begin
                            r.out_payload = level_take(l);
                            r.status      = ST_OK;
                        end
                    end
                end
                REQ_ACCEL:
                begin
                    // whole low level moves behind the high tail, order kept
                    while (level_q[LVL_LOW].size() != 0)
                        level_append(LVL_HIGH, level_take(LVL_LOW));
                end
                default:
                begin
                end
            endcase
            r.entries_held = HELD_W'(held_total());
            return r;
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [PRIO_W-1:0] lvl,
                                   logic [DATA_W-1:0] data);
            due_rsp.insert(due_rsp.size(), queue_response(kind, lvl, data));
        endfunction

        function void check_response(logic [DATA_W-1:0] pl, logic [STAT_W-1:0] st,
                                     logic [HELD_W-1:0] held);
            rsp_item_t exp_rsp;
            rsp_seen++;
            if (due_rsp.size() == 0)
            begin
                report_mismatch($sformatf("item %0d not awaited: payload %h status %0d held %0d",
                                          rsp_seen, pl, st, held));
                return;
            end
            exp_rsp = due_rsp[0];
            due_rsp.delete(0);
            if (pl !== exp_rsp.out_payload)
                report_mismatch($sformatf("item %0d out_payload %h, want %h",
                                          rsp_seen, pl, exp_rsp.out_payload));
            if (st !== exp_rsp.status)
                report_mismatch($sformatf("item %0d status %0d, want %s",
                                          rsp_seen, st, exp_rsp.status.name()));
            if (held !== exp_rsp.entries_held)
                report_mismatch($sformatf("item %0d entries_held %0d, want %0d",
                                          rsp_seen, held, exp_rsp.entries_held));
        endfunction

        function int pending();
            return due_rsp.size();
        endfunction

    endclass

endpackage

// ===== tb/three_level_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_tb
// drives put, get and accelerate requests into the priority queue, first a
// directed list of corner cases, then random traffic that alternates between
// filling, draining and balanced stretches; both channels idle at random and
// every response is checked against the scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module three_level_priority_queue_tb;

    import tlpq_pkg::*;
    import tlpq_tb_pkg::*;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_t;

    localparam int RANDOM_ITEMS = 525;
    localparam int DRAIN_WAIT   = 20;

    logic clk;
    logic rst_n;

    tlpq_req_if req_ch ();
    tlpq_rsp_if rsp_ch ();

    tlpq_scoreboard sb;

    int burst_left;

    three_level_priority_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // watchdog
    initial
    begin
        #(1_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // payload with extra weight on the extremes
    function automatic logic [DATA_W-1:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // put level, now and then the invalid code
    function automatic logic [PRIO_W-1:0] pick_level();
        if ($urandom_range(0, 19) == 0)
            return LVL_INVALID;
        return PRIO_W'($urandom_range(0, 2));
    endfunction

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one request, held until accepted
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [PRIO_W-1:0] lvl,
                                input logic [DATA_W-1:0] data);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.priority_req <= lvl;
        req_ch.payload      <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, lvl, data);
        pace_sender();
    endtask

    // corner cases of the opening part
    task automatic run_directed();
        // empty queue: get reports empty, accelerate does nothing
        send_request(REQ_GET, LVL_HIGH, '1);
        send_request(REQ_ACCEL, LVL_INVALID, '1);
        // invalid level and meaningless request code
        send_request(REQ_PUT, LVL_INVALID, '1);
        send_request(REQ_NONE, LVL_INVALID, '1);
        // accelerate onto an empty high level
        send_request(REQ_PUT, LVL_LOW, '0);
        send_request(REQ_PUT, LVL_LOW, '1);
        send_request(REQ_ACCEL, LVL_LOW, '0);
        // accelerate behind a non-empty high level
        send_request(REQ_PUT, LVL_NORMAL, 32'h5a5a_5a5a);
        send_request(REQ_PUT, LVL_HIGH, 32'ha5a5_a5a5);
        send_request(REQ_PUT, LVL_LOW, 32'h0000_0001);
        send_request(REQ_ACCEL, LVL_NORMAL, 32'h8000_0000);
        // drain in priority order, then once more on empty
        repeat (6) send_request(REQ_GET, LVL_LOW, '0);
        send_request(REQ_PUT, LVL_INVALID, '0);
        send_request(REQ_NONE, LVL_LOW, '0);
        // normal goes out ahead of low
        send_request(REQ_PUT, LVL_LOW, 32'h0000_0003);
        send_request(REQ_PUT, LVL_NORMAL, 32'h0000_0007);
        send_request(REQ_GET, LVL_HIGH, '1);
        send_request(REQ_GET, LVL_NORMAL, '1);
    endtask

    // random traffic in fill, drain and balanced stretches so the store
    // runs full and empty several times
    task automatic run_random(input int n_items);
        int       done_items;
        int       seg_left;
        int       pick;
        traffic_t mix;
        logic [REQ_W-1:0]  kind;
        logic [PRIO_W-1:0] lvl;
        logic [DATA_W-1:0] data;
        done_items = 0;
        seg_left   = 110;
        mix        = MIX_FILL;
        while (done_items < n_items)
        begin
            if (seg_left == 0)
            begin
                case (mix)
                    MIX_FILL:  mix = MIX_DRAIN;
                    MIX_DRAIN: mix = MIX_EVEN;
                    default:   mix = MIX_FILL;
                endcase
                seg_left = (mix == MIX_EVEN) ? 90 : 110;
            end
            pick = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  pick = (pick < 78) ? 0 : (pick < 90) ? 1 : (pick < 97) ? 2 : 3;
                MIX_DRAIN: pick = (pick < 15) ? 0 : (pick < 85) ? 1 : (pick < 96) ? 2 : 3;
                default:   pick = (pick < 45) ? 0 : (pick < 85) ? 1 : (pick < 96) ? 2 : 3;
            endcase
            case (pick)
                0:       kind = REQ_PUT;
                1:       kind = REQ_GET;
                2:       kind = REQ_ACCEL;
                default: kind = REQ_NONE;
            endcase
            lvl  = (kind == REQ_PUT) ? pick_level() : PRIO_W'($urandom_range(0, 3));
            data = pick_payload();
            send_request(kind, lvl, data);
            seg_left--;
            done_items++;
        end
    endtask

    // response side: stalls on its own schedule, checks every item taken
    initial
    begin
        int cyc;
        cyc = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.out_payload, rsp_ch.status, rsp_ch.entries_held);
            cyc++;
            case ((cyc / 150) % 4)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                2:       rsp_ch.ready <= (cyc % 3 == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // main sequence
    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n               = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_PUT;
        req_ch.priority_req <= LVL_LOW;
        req_ch.payload      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        req_ch.valid <= 1'b0;

        // let the last responses come out, then a short quiet window
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== three_level_priority_queue.f =====
+incdir+rtl
rtl/tlpq_pkg.sv
rtl/tlpq_req_if.sv
rtl/tlpq_rsp_if.sv
rtl/tlpq_ctrl.sv
rtl/tlpq_datapath.sv
rtl/three_level_priority_queue.sv
tb/tlpq_tb_pkg.sv
tb/three_level_priority_queue_tb.sv
